>>> sv/pkld_pkg.sv
// Package for the per-key lockout debouncer.
// Holds item types, controller/datapath command and status structs, and constants.
// No dependencies.
package pkld_pkg;

	localparam int KEY_W          = 6;
	localparam int TIME_W         = 64;
	localparam int LOCKOUT_W      = 20;
	localparam int KEY_COUNT_DEF  = 64;
	localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = LOCKOUT_W'(10 * 1000);

	typedef enum logic [1:0] {
		ST_UNCHANGED  = 2'd0,
		ST_ACCEPTED   = 2'd1,
		ST_SUPPRESSED = 2'd2
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_time;
		logic [KEY_W-1:0]  key_index;
		logic              raw_pressed;
	} in_item_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key_out;
		status_t           status;
		logic              level;
		logic [TIME_W-1:0] since_last;
	} out_item_t;

	typedef struct packed {
		logic clr_en;
		logic load_en;
		logic eval_en;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_last;
	} dp_stat_t;

endpackage

>>> sv/pkld_ctrl.sv
// Controller for the per-key lockout debouncer.
// Sequences the post-reset clearing pass, item load and evaluation.
// Depends on pkld_pkg.
module pkld_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pkld_pkg::dp_stat_t stat,
	output pkld_pkg::ctl_cmd_t cmd,
	output logic              busy
);
	import pkld_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (stat.clr_last) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_EVAL;
						busy_q  <= 1'b1;
					end
				end
				S_EVAL: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_CLEAR;
					busy_q  <= 1'b1;
				end
			endcase
		end
	end

	assign busy        = busy_q;
	assign cmd.clr_en  = (state_q == S_CLEAR);
	assign cmd.load_en = start && !busy_q;
	assign cmd.eval_en = (state_q == S_EVAL);

endmodule

>>> sv/pkld_dp.sv
// Datapath for the per-key lockout debouncer.
// Holds the per-key state memory, lockout register, elapsed-time compare and result register.
// Depends on pkld_pkg.
module pkld_dp #(
	parameter int KEY_COUNT = pkld_pkg::KEY_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pkld_pkg::ctl_cmd_t                  cmd,
	output pkld_pkg::dp_stat_t                  stat,
	input  pkld_pkg::in_item_t                  sample,
	input  logic                                cfg_we,
	input  logic [pkld_pkg::LOCKOUT_W-1:0]      cfg_data,
	output pkld_pkg::out_item_t                 result,
	output logic                                done
);
	import pkld_pkg::*;

	localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

	logic [TIME_W-1:0]    mem [KEY_COUNT];
	logic [TIME_W-1:0]    rd_q;
	logic [TIME_W-1:0]    now_q;
	logic [KEY_W-1:0]     key_q;
	logic [AW-1:0]        addr_q;
	logic                 lvl_q;
	logic                 inrange_q;
	logic [LOCKOUT_W-1:0] lockout_q;
	logic [AW-1:0]        clr_cnt_q;
	out_item_t            result_q;
	logic                 done_q;

	logic [AW-1:0]     in_addr;
	logic              in_range;
	logic [TIME_W-1:0] last_time;
	logic [TIME_W-1:0] since;
	logic              differ;
	logic              pass;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [TIME_W-1:0] wr_data;

	assign in_addr  = AW'(sample.key_index);
	assign in_range = int'(sample.key_index) < KEY_COUNT;

	assign last_time = {rd_q[TIME_W-2:0], 1'b0};
	assign since     = now_q - last_time;
	assign differ    = inrange_q && (lvl_q != rd_q[TIME_W-1]);
	assign pass      = since >= TIME_W'(lockout_q);

	assign wr_en   = cmd.clr_en || (cmd.eval_en && differ && pass);
	assign wr_addr = cmd.clr_en ? clr_cnt_q : addr_q;
	assign wr_data = cmd.clr_en ? '0 : {lvl_q, now_q[TIME_W-1:1]};

	// Memory: bit 63 accepted level, bits 62:0 change time without its lowest bit.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.load_en) begin
			rd_q <= mem[in_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en) begin
			now_q     <= sample.now_time;
			key_q     <= sample.key_index;
			addr_q    <= in_addr;
			lvl_q     <= sample.raw_pressed;
			inrange_q <= in_range;
		end
		if (cmd.eval_en) begin
			result_q.key_out    <= key_q;
			result_q.level      <= lvl_q;
			result_q.status     <= !differ ? ST_UNCHANGED :
			                       (pass ? ST_ACCEPTED : ST_SUPPRESSED);
			result_q.since_last <= differ ? since : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q <= LOCKOUT_RESET;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				lockout_q <= cfg_data;
			end
			if (cmd.clr_en) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			done_q <= cmd.eval_en;
		end
	end

	assign stat.clr_last = (clr_cnt_q == AW'(KEY_COUNT - 1));
	assign result        = result_q;
	assign done          = done_q;

endmodule

>>> sv/per_key_lockout_debouncer.sv
// Top level of the per-key lockout debouncer.
// Joins pkld_ctrl and pkld_dp; depends on pkld_pkg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  sample   | start, busy            | now_time, key_index, raw_pressed
//  result   | done (one-cycle pulse) | key_out, status, level, since_last
//  config   | cfg_valid, cfg_ready   | cfg_data (lockout_usec)
//
// Each item is a memory read of the key's entry, then compare and write-back.
// done pulses when the result register is loaded and busy has dropped; a new item may be taken in that same cycle.
// After reset a clearing pass over all KEY_COUNT entries holds busy high; config is taken at all times.
// The receiver cannot stall: each result is flagged by done for one cycle only.
module per_key_lockout_debouncer #(
	parameter int KEY_COUNT = pkld_pkg::KEY_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  pkld_pkg::in_item_t             sample,
	output logic                           done,
	output pkld_pkg::out_item_t            result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pkld_pkg::LOCKOUT_W-1:0] cfg_data
);
	import pkld_pkg::*;

	ctl_cmd_t ctl_cmd;
	dp_stat_t dp_stat;

	assign cfg_ready = 1'b1;

	pkld_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dp_stat),
		.cmd    (ctl_cmd),
		.busy   (busy)
	);

	pkld_dp #(
		.KEY_COUNT (KEY_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ctl_cmd),
		.stat     (dp_stat),
		.sample   (sample),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.result   (result),
		.done     (done)
	);

	a_done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result missing two cycles after accept");

	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a matching item");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.clr_en |-> !done && !ctl_cmd.eval_en)
		else $error("result during clearing pass");

endmodule
